>>> design/xtea_pkg.sv
`default_nettype none

package xtea_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 64;
   localparam int unsigned ROUND_W = 8;
   localparam int unsigned CNT_W   = ROUND_W + 1;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned KEY_N   = 4;

   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
   localparam int unsigned MIX_SHL = 4;
   localparam int unsigned MIX_SHR = 5;
   localparam int unsigned KEY_HI_SHR = 11;

   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 8'd32;

   typedef enum logic [INDEX_W-1:0] {
      REG_KEY_WORD0   = 3'd0,
      REG_KEY_WORD1   = 3'd1,
      REG_KEY_WORD2   = 3'd2,
      REG_KEY_WORD3   = 3'd3,
      REG_INIT_VECTOR = 3'd4,
      REG_ROUND_COUNT = 3'd5,
      REG_DECRYPT     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
      return ((w << MIX_SHL) ^ (w >> MIX_SHR)) + w;
   endfunction

endpackage

`default_nettype wire

>>> design/xtea_cbc_block_cipher.sv
`default_nettype none

// XTEA in CBC mode, one 64-bit block (two 32-bit words) per request word.
// A shared half-round unit updates one cipher word per cycle while the
// block runs, and the request side stalls until the result has been
// written to the output register, which may wait on the response side.
// The result sits in an output register until taken; the next request is
// accepted in the cycle after the result has been written there.
// Configuration (key, IV, round count, mode) must be written only while
// the block is idle; the block itself does not enforce this. first_block
// restarts the chain from the IV; otherwise the last ciphertext block is
// used, zero after reset.
module xtea_cbc_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_in_word0,
   input  wire logic [31:0] req_in_word1,
   input  wire logic        req_first_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_word0,
   output logic [31:0]      rsp_out_word1
);

   localparam int unsigned WW = xtea_pkg::WORD_W;
   localparam int unsigned BW = xtea_pkg::BLOCK_W;

   logic [WW-1:0]                  key_ff [xtea_pkg::KEY_N];
   logic [BW-1:0]                  iv_ff;
   logic [xtea_pkg::ROUND_W-1:0]   rounds_ff;
   logic                           decrypt_ff;

   xtea_pkg::state_type            state_ff, state_in;
   logic [WW-1:0]                  a_ff, a_in, b_ff, b_in, s_ff, s_in;
   logic [xtea_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           phase_ff, phase_in;
   logic [BW-1:0]                  prev_ff, prev_in;
   logic [BW-1:0]                  chain_ff, chain_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                  rsp_ff, rsp_in;

   logic                           req_take, rsp_free;
   logic [BW-1:0]                  prev_sel, blk, result;
   logic                           use_hi;
   logic [1:0]                     key_idx;
   logic [WW-1:0]                  src, dst, term, dst_new, s_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < xtea_pkg::KEY_N; i++) key_ff[i] <= '0;
         iv_ff      <= '0;
         rounds_ff  <= xtea_pkg::ROUND_COUNT_RESET;
         decrypt_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            xtea_pkg::REG_KEY_WORD0:   key_ff[0]  <= csr_write_data[WW-1:0];
            xtea_pkg::REG_KEY_WORD1:   key_ff[1]  <= csr_write_data[WW-1:0];
            xtea_pkg::REG_KEY_WORD2:   key_ff[2]  <= csr_write_data[WW-1:0];
            xtea_pkg::REG_KEY_WORD3:   key_ff[3]  <= csr_write_data[WW-1:0];
            xtea_pkg::REG_INIT_VECTOR: iv_ff      <= csr_write_data;
            xtea_pkg::REG_ROUND_COUNT: rounds_ff  <= csr_write_data[xtea_pkg::ROUND_W-1:0];
            xtea_pkg::REG_DECRYPT:     decrypt_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != xtea_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign prev_sel = req_first_block ? iv_ff : chain_ff;
   assign blk      = {req_in_word1, req_in_word0};

   // half-round unit: encrypt updates a then b, decrypt b then a
   always_comb begin
      use_hi  = decrypt_ff ? !phase_ff : phase_ff;
      key_idx = use_hi ? s_ff[xtea_pkg::KEY_HI_SHR +: 2] : s_ff[1:0];
      if (decrypt_ff ^ phase_ff) begin
         src = a_ff;
         dst = b_ff;
      end else begin
         src = b_ff;
         dst = a_ff;
      end
      term    = xtea_pkg::mix_word(src) ^ (s_ff + key_ff[key_idx]);
      dst_new = decrypt_ff ? dst - term : dst + term;
      s_step  = decrypt_ff ? s_ff - xtea_pkg::XTEA_DELTA : s_ff + xtea_pkg::XTEA_DELTA;
   end

   assign result = decrypt_ff ? ({b_ff, a_ff} ^ prev_ff) : {b_ff, a_ff};

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      prev_in      = prev_ff;
      chain_in     = chain_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         xtea_pkg::ST_IDLE: begin
            if (req_take) begin
               prev_in  = prev_sel;
               phase_in = 1'b0;
               cnt_in   = {rounds_ff, 1'b0};
               if (decrypt_ff) begin
                  {b_in, a_in} = blk;
                  chain_in     = blk;
                  s_in = WW'(xtea_pkg::XTEA_DELTA * WW'(rounds_ff));
               end else begin
                  {b_in, a_in} = blk ^ prev_sel;
                  s_in         = '0;
               end
               state_in = (rounds_ff == '0) ? xtea_pkg::ST_FINISH : xtea_pkg::ST_RUN;
            end
         end
         xtea_pkg::ST_RUN: begin
            if (decrypt_ff ^ phase_ff) b_in = dst_new;
            else                       a_in = dst_new;
            if (!phase_ff) s_in = s_step;
            phase_in = !phase_ff;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == xtea_pkg::CNT_W'(1)) state_in = xtea_pkg::ST_FINISH;
         end
         xtea_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               if (!decrypt_ff) chain_in = result;
               state_in = xtea_pkg::ST_IDLE;
            end
         end
         default: state_in = xtea_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xtea_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      s_ff     <= s_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      prev_ff  <= prev_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word0 = rsp_ff[WW-1:0];
   assign rsp_out_word1 = rsp_ff[BW-1:WW];

endmodule

`default_nettype wire
